>>> sv/rta_pkg.sv
// Shared types and constants of the transmit rate adaptation engine.
// No dependencies; every other file but rta_ram imports this package.
package rta_pkg;

    localparam int NUM_RATES  = 8;
    localparam int NUM_LINKS  = 4;

    localparam int RIDX_W     = (NUM_RATES > 1) ? $clog2(NUM_RATES) : 1;
    localparam int LIDX_W     = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;
    localparam int STAT_DEPTH = NUM_LINKS * NUM_RATES;
    localparam int ADDR_W     = $clog2(STAT_DEPTH);

    localparam int CNT_W      = 32;
    localparam int EWMA_W     = 7;
    localparam int THR_W      = 16;
    localparam int CODE_W     = 16;
    localparam int RELOAD_W   = 16;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_W      = 39;
    localparam int DCNT_W     = 6;

    // ewma (at most 100) times a 16-bit code fits in 23 bits; divide it by 100
    // as a multiply by ceil(2^32 / 100) and a shift by 32, exact below 2^30
    localparam int THR_NUM_W  = 23;
    localparam int RECIP_W    = 26;
    localparam int PROD_W     = THR_NUM_W + RECIP_W;
    localparam int THR_SHIFT  = 32;
    localparam logic [RECIP_W-1:0] THR_RECIP = 26'd42949673;

    localparam logic [EWMA_W-1:0]   PCT_FULL    = 7'd100;
    localparam logic [RELOAD_W-1:0] RELOAD_INIT = 16'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE   = 2'd0,
        CFG_CODES_LO = 2'd1,
        CFG_CODES_HI = 2'd2,
        CFG_RELOAD   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic       opcode;
        logic [1:0] link_id;
        logic       success;
        logic [7:0] retries;
        logic       probe_frame;
    } in_item_t;

    typedef struct packed {
        logic [1:0] out_link;
        logic [2:0] current_rate;
        logic       rate_changed;
        logic       probing_now;
        logic [2:0] probe_rate;
    } out_item_t;

    typedef struct packed {
        logic [CNT_W-1:0]  attempt_count;
        logic [CNT_W-1:0]  success_count;
        logic [CNT_W-1:0]  retry_count;
        logic [CNT_W-1:0]  failure_count;
        logic [EWMA_W-1:0] ewma_percent;
        logic [THR_W-1:0]  throughput_est;
    } stat_t;

    localparam int STAT_W = $bits(stat_t);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE, ST_PROBE_ACC, ST_FOLD_RD, ST_FOLD_WAIT, ST_FOLD_SUM,
        ST_PCT_MUL, ST_PCT_DIV, ST_PCT_WAIT, ST_EWMA, ST_THR_MUL, ST_THR_DIV,
        ST_THR_WAIT, ST_FOLD_WR, ST_SCAN_INIT, ST_SCAN_RD, ST_SCAN_CMP, ST_FINISH
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_PROBE_ACC, OP_FOLD_RD, OP_FOLD_SUM, OP_PCT_MUL, OP_PCT_DIV,
        OP_EWMA, OP_THR_MUL, OP_THR_DIV, OP_FOLD_WR, OP_SCAN_INIT, OP_SCAN_RD,
        OP_SCAN_CMP, OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   load_item;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic item_ok;
        logic is_tick;
        logic probe_hit;
        logic probe_active;
        logic att_zero;
        logic div_done;
        logic scan_last;
    } dp_status_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

>>> sv/tx_rate_adaptation_engine_top.sv
// Per-link transmit rate selection: a status transaction either lands in the probe
// counters or updates a rate's statistics; a tick folds a pending probe, if any, into
// the statistics and then scans the link's rates. A statistics update runs the success
// percentage through the bit-serial divider (the throughput's division by 100 is a
// reciprocal multiply), and the scan reads the eight rate entries one after another
// from the statistics RAM. One transaction is in work at a time; a tick's result
// waits in an output register.
// Depends on rta_pkg, rta_ctrl and rta_datapath.
module tx_rate_adaptation_engine_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rta_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rta_pkg::out_item_t              m_data,
    input  logic                            cfg_we,
    input  logic [rta_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rta_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rta_pkg::*;

    logic                  enable_reg;
    logic [CFG_DATA_W-1:0] codes_lo_reg;
    logic [CFG_DATA_W-1:0] codes_hi_reg;
    logic [RELOAD_W-1:0]   reload_reg;
    logic                  m_valid_reg;
    out_item_t             m_data_reg;
    dp_cmd_t               cmd;
    dp_status_t            status;
    out_item_t             result;
    logic                  out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= 1'b0;
            codes_lo_reg <= '0;
            codes_hi_reg <= '0;
            reload_reg   <= RELOAD_INIT;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ENABLE:   enable_reg   <= cfg_data[0];
                CFG_CODES_LO: codes_lo_reg <= cfg_data;
                CFG_CODES_HI: codes_hi_reg <= cfg_data;
                CFG_RELOAD:   reload_reg   <= cfg_data[RELOAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= result;
        end
    end

    rta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    rta_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_item       (s_data),
        .enable       (enable_reg),
        .rate_codes   ({codes_hi_reg, codes_lo_reg}),
        .probe_reload (reload_reg),
        .result       (result)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule

>>> sv/rta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> sv/rta_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rta_pkg.
module rta_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [rta_pkg::NUM_W-1:0] num,
    input  logic [rta_pkg::CNT_W-1:0] den,
    output logic                     done,
    output logic [rta_pkg::NUM_W-1:0] quo
);
    import rta_pkg::*;

    logic              busy_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [CNT_W:0]    rem_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [CNT_W:0]    rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg[CNT_W-1:0], quo_reg[NUM_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DCNT_W'(NUM_W - 1);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= fits ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done = !busy_reg;
    assign quo  = quo_reg;
endmodule

>>> sv/rta_datapath.sv
// Datapath: rate statistics memory, per-link state, fold arithmetic and scan.
// Depends on rta_pkg, rta_ram and rta_div.
module rta_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rta_pkg::dp_cmd_t                cmd,
    output rta_pkg::dp_status_t             status,
    input  rta_pkg::in_item_t               s_item,
    input  logic                            enable,
    input  logic [2*rta_pkg::CFG_DATA_W-1:0] rate_codes,
    input  logic [rta_pkg::RELOAD_W-1:0]    probe_reload,
    output rta_pkg::out_item_t              result
);
    import rta_pkg::*;

    in_item_t          item_reg;
    logic [RIDX_W-1:0] sel_reg   [NUM_LINKS];
    logic [RIDX_W-1:0] pidx_reg  [NUM_LINKS];
    logic [RELOAD_W-1:0] cdown_reg [NUM_LINKS];
    logic [CNT_W-1:0]  patt_reg  [NUM_LINKS];
    logic [CNT_W-1:0]  psuc_reg  [NUM_LINKS];
    logic [CNT_W-1:0]  pret_reg  [NUM_LINKS];
    logic              probe_active_reg;
    logic              valid_reg [STAT_DEPTH];
    logic              rd_vld_reg;
    logic [RIDX_W-1:0] fold_rate_reg;
    stat_t             work_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [PROD_W-1:0] thr_prod_reg;
    logic [RIDX_W-1:0] scan_idx_reg;
    logic [RIDX_W-1:0] best_reg;
    logic [THR_W-1:0]  best_t_reg;

    logic [LIDX_W-1:0] lnk;
    logic              link_ok;
    logic              ram_re;
    logic              ram_we;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic [STAT_W-1:0] ram_rdata;
    stat_t             rd_stat;
    stat_t             base;
    stat_t             wr_stat;
    logic [RIDX_W-1:0] fold_src;
    logic [CNT_W-1:0]  add_att;
    logic [CNT_W-1:0]  add_suc;
    logic [CNT_W-1:0]  add_ret;
    logic [CNT_W-1:0]  add_fail;
    logic              div_start;
    logic [CNT_W-1:0]  div_den;
    logic              div_done;
    logic [NUM_W-1:0]  div_q;
    logic [EWMA_W-1:0] pct;
    logic [9:0]        ewma_sum;
    logic [CODE_W-1:0] code;
    logic [THR_W-1:0]  scan_thr;
    logic              cd_zero;
    logic [RIDX_W-1:0] next_pidx;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [LIDX_W-1:0] l,
                                                  input logic [RIDX_W-1:0] r);
        return ADDR_W'(int'(l) * NUM_RATES + int'(r));
    endfunction

    assign lnk     = LIDX_W'(item_reg.link_id);
    assign link_ok = int'(item_reg.link_id) < NUM_LINKS;
    assign fold_src = item_reg.opcode ? pidx_reg[lnk] : sel_reg[lnk];

    assign ram_re = (cmd.op == OP_FOLD_RD) || (cmd.op == OP_SCAN_RD);
    assign raddr  = (cmd.op == OP_FOLD_RD) ? addr_of(lnk, fold_src)
                                           : addr_of(lnk, scan_idx_reg);
    assign ram_we = cmd.op == OP_FOLD_WR;
    assign waddr  = addr_of(lnk, fold_rate_reg);

    always_comb begin
        wr_stat = work_reg;
        if (work_reg.attempt_count != '0) begin
            wr_stat.throughput_est = thr_prod_reg[THR_SHIFT +: THR_W];
        end
    end

    rta_ram #(.WIDTH(STAT_W), .DEPTH(STAT_DEPTH)) u_stat_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wr_stat),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign rd_stat = stat_t'(ram_rdata);
    assign base    = rd_vld_reg ? rd_stat : '0;

    // Sources of a fold: one status frame, or the link's probe counters on a tick
    always_comb begin
        if (item_reg.opcode) begin
            add_att = patt_reg[lnk];
            add_suc = psuc_reg[lnk];
            add_ret = pret_reg[lnk];
        end else begin
            add_att = CNT_W'(1);
            add_suc = CNT_W'(item_reg.success);
            add_ret = CNT_W'(item_reg.retries);
        end
        add_fail = (add_suc <= add_att) ? (add_att - add_suc) : '0;
    end

    assign div_start = cmd.op == OP_PCT_DIV;
    assign div_den   = work_reg.attempt_count;

    rta_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_q)
    );

    assign pct      = (div_q > NUM_W'(PCT_FULL)) ? PCT_FULL : div_q[EWMA_W-1:0];
    assign ewma_sum = 10'(work_reg.ewma_percent) * 10'd7 + 10'(pct);
    assign code     = rate_codes[int'(fold_rate_reg) * CODE_W +: CODE_W];
    assign scan_thr = rd_vld_reg ? rd_stat.throughput_est : '0;
    assign cd_zero  = cdown_reg[lnk] == '0;
    assign next_pidx = (best_reg == RIDX_W'(NUM_RATES - 1)) ? '0 : best_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            rd_vld_reg <= valid_reg[raddr];
        end
        if (cmd.load_item) begin
            item_reg <= s_item;
        end
        unique case (cmd.op)
            OP_FOLD_RD: begin
                fold_rate_reg <= fold_src;
            end
            OP_FOLD_SUM: begin
                work_reg.attempt_count  <= sat_add(base.attempt_count, add_att);
                work_reg.success_count  <= sat_add(base.success_count, add_suc);
                work_reg.retry_count    <= sat_add(base.retry_count, add_ret);
                work_reg.failure_count  <= sat_add(base.failure_count, add_fail);
                work_reg.ewma_percent   <= base.ewma_percent;
                work_reg.throughput_est <= base.throughput_est;
            end
            OP_PCT_MUL: begin
                num_reg <= NUM_W'(work_reg.success_count) * NUM_W'(PCT_FULL);
            end
            OP_EWMA: begin
                work_reg.ewma_percent <= ewma_sum[9:3];
            end
            OP_THR_MUL: begin
                num_reg <= NUM_W'(work_reg.ewma_percent) * NUM_W'(code);
            end
            OP_THR_DIV: begin
                // divide by 100 through the reciprocal; the quotient sits above THR_SHIFT
                thr_prod_reg <= PROD_W'(num_reg[THR_NUM_W-1:0]) * PROD_W'(THR_RECIP);
            end
            OP_SCAN_INIT: begin
                scan_idx_reg <= '0;
                best_reg     <= '0;
                best_t_reg   <= '0;
            end
            OP_SCAN_CMP: begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (scan_thr > best_t_reg) begin
                    best_t_reg <= scan_thr;
                    best_reg   <= scan_idx_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_active_reg <= 1'b0;
            for (int i = 0; i < NUM_LINKS; i++) begin
                sel_reg[i]   <= '0;
                pidx_reg[i]  <= '0;
                cdown_reg[i] <= RELOAD_INIT;
                patt_reg[i]  <= '0;
                psuc_reg[i]  <= '0;
                pret_reg[i]  <= '0;
            end
            for (int j = 0; j < STAT_DEPTH; j++) begin
                valid_reg[j] <= 1'b0;
            end
        end else begin
            unique case (cmd.op)
                OP_PROBE_ACC: begin
                    patt_reg[lnk] <= sat_add(patt_reg[lnk], CNT_W'(1));
                    psuc_reg[lnk] <= sat_add(psuc_reg[lnk], CNT_W'(item_reg.success));
                    pret_reg[lnk] <= sat_add(pret_reg[lnk], CNT_W'(item_reg.retries));
                end
                OP_FOLD_WR: begin
                    valid_reg[waddr] <= 1'b1;
                    // a tick folds the pending probe: clear its counters
                    if (item_reg.opcode) begin
                        patt_reg[lnk]    <= '0;
                        psuc_reg[lnk]    <= '0;
                        pret_reg[lnk]    <= '0;
                        probe_active_reg <= 1'b0;
                    end
                end
                OP_FINISH: begin
                    sel_reg[lnk] <= best_reg;
                    if (cd_zero) begin
                        pidx_reg[lnk]    <= next_pidx;
                        probe_active_reg <= 1'b1;
                        cdown_reg[lnk]   <= probe_reload;
                    end else begin
                        cdown_reg[lnk] <= cdown_reg[lnk] - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign result.out_link     = item_reg.link_id;
    assign result.current_rate = 3'(best_reg);
    assign result.rate_changed = best_reg != sel_reg[lnk];
    assign result.probing_now  = cd_zero | probe_active_reg;
    assign result.probe_rate   = cd_zero ? 3'(next_pidx) : 3'(pidx_reg[lnk]);

    assign status.item_ok      = enable && link_ok;
    assign status.is_tick      = item_reg.opcode;
    assign status.probe_hit    = probe_active_reg && item_reg.probe_frame;
    assign status.probe_active = probe_active_reg;
    assign status.att_zero     = work_reg.attempt_count == '0;
    assign status.div_done     = div_done;
    assign status.scan_last    = scan_idx_reg == RIDX_W'(NUM_RATES - 1);
endmodule

>>> sv/rta_ctrl.sv
// Controller state machine sequencing the datapath for each transaction.
// Depends on rta_pkg.
module rta_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                out_free,
    input  rta_pkg::dp_status_t status,
    output rta_pkg::dp_cmd_t    cmd
);
    import rta_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_DECODE;
            ST_DECODE: begin
                if (!status.item_ok) begin
                    state_next = ST_IDLE;
                end else if (status.is_tick) begin
                    state_next = status.probe_active ? ST_FOLD_RD : ST_SCAN_INIT;
                end else begin
                    state_next = status.probe_hit ? ST_PROBE_ACC : ST_FOLD_RD;
                end
            end
            ST_PROBE_ACC: state_next = ST_IDLE;
            ST_FOLD_RD:   state_next = ST_FOLD_WAIT;
            ST_FOLD_WAIT: state_next = ST_FOLD_SUM;
            ST_FOLD_SUM:  state_next = ST_PCT_MUL;
            // skip the estimate update when the rate has no attempts
            ST_PCT_MUL:   state_next = status.att_zero ? ST_FOLD_WR : ST_PCT_DIV;
            ST_PCT_DIV:   state_next = ST_PCT_WAIT;
            ST_PCT_WAIT:  if (status.div_done) state_next = ST_EWMA;
            ST_EWMA:      state_next = ST_THR_MUL;
            ST_THR_MUL:   state_next = ST_THR_DIV;
            ST_THR_DIV:   state_next = ST_THR_WAIT;
            ST_THR_WAIT:  if (status.div_done) state_next = ST_FOLD_WR;
            ST_FOLD_WR:   state_next = status.is_tick ? ST_SCAN_INIT : ST_IDLE;
            ST_SCAN_INIT: state_next = ST_SCAN_RD;
            ST_SCAN_RD:   state_next = ST_SCAN_CMP;
            ST_SCAN_CMP:  state_next = status.scan_last ? ST_FINISH : ST_SCAN_RD;
            ST_FINISH:    if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op        = OP_NONE;
        cmd.load_item = 1'b0;
        cmd.out_load  = 1'b0;
        s_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            ST_PROBE_ACC: cmd.op = OP_PROBE_ACC;
            ST_FOLD_RD:   cmd.op = OP_FOLD_RD;
            ST_FOLD_SUM:  cmd.op = OP_FOLD_SUM;
            ST_PCT_MUL:   cmd.op = OP_PCT_MUL;
            ST_PCT_DIV:   cmd.op = OP_PCT_DIV;
            ST_EWMA:      cmd.op = OP_EWMA;
            ST_THR_MUL:   cmd.op = OP_THR_MUL;
            ST_THR_DIV:   cmd.op = OP_THR_DIV;
            ST_FOLD_WR:   cmd.op = OP_FOLD_WR;
            ST_SCAN_INIT: cmd.op = OP_SCAN_INIT;
            ST_SCAN_RD:   cmd.op = OP_SCAN_RD;
            ST_SCAN_CMP:  cmd.op = OP_SCAN_CMP;
            ST_FINISH: begin
                if (out_free) begin
                    cmd.op       = OP_FINISH;
                    cmd.out_load = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end
endmodule

>>> tb/sv/tx_rate_adaptation_engine_top_tb.sv
`timescale 1ns / 100ps
// Testbench for tx_rate_adaptation_engine_top: random status and tick transactions with
// random idling on both sides, checked against an in-bench rate statistics predictor.
// Depends on rta_pkg and the engine RTL.
module tx_rate_adaptation_engine_top_tb;
    import rta_pkg::*;

    localparam int RUN_LIMIT = 4000000;
    localparam int SETTLE    = 300;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;
    logic       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tx_rate_adaptation_engine_top uut (.*);

    always #5 aclk = ~aclk;

    // predictor state
    logic        en_q;
    logic [63:0] codes_lo_q, codes_hi_q;
    logic [15:0] reload_q;
    logic [31:0] att_q [4][8];
    logic [31:0] suc_q [4][8];
    logic [31:0] ret_q [4][8];
    logic [31:0] fail_q [4][8];
    logic [6:0]  ewma_q [4][8];
    logic [15:0] thr_q [4][8];
    logic [2:0]  sel_q [4];
    logic [2:0]  pidx_q [4];
    logic [15:0] cdown_q [4];
    logic [31:0] p_att_q [4], p_suc_q [4], p_ret_q [4];
    logic        probing_q;

    in_item_t  pending_items [$];
    out_item_t expected_ticks [$];
    int        mismatches = 0;
    int        ticks_seen = 0;
    int        sent_items = 0;
    int        probes_started = 0;
    int        cycles = 0;
    bit        no_idle = 0;

    function automatic logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [15:0] code_at(int idx);
        logic [63:0] r;
        r = (idx < 4) ? codes_lo_q : codes_hi_q;
        return r[(idx % 4)*16 +: 16];
    endfunction

    task automatic fold_stats(int lk, int rt, logic [31:0] a, logic [31:0] s, logic [31:0] r);
        logic [63:0] pct;
        logic [31:0] e;
        att_q[lk][rt]  = sat32(att_q[lk][rt], a);
        suc_q[lk][rt]  = sat32(suc_q[lk][rt], s);
        ret_q[lk][rt]  = sat32(ret_q[lk][rt], r);
        fail_q[lk][rt] = sat32(fail_q[lk][rt], (s <= a) ? a - s : 32'd0);
        if (att_q[lk][rt] != 0) begin
            pct = (64'(suc_q[lk][rt]) * 100) / att_q[lk][rt];
            if (pct > 100) pct = 100;
            e = (32'(ewma_q[lk][rt]) * 7 + 32'(pct)) / 8;
            ewma_q[lk][rt] = e[6:0];
            thr_q[lk][rt] = 16'((e * 32'(code_at(rt))) / 100);
        end
    endtask

    task automatic predict_item(in_item_t it);
        int lk, best;
        logic [15:0] best_t;
        out_item_t o;
        if (!en_q) return;
        lk = it.link_id;
        if (it.opcode == 1'b0) begin
            if (probing_q && it.probe_frame) begin
                p_att_q[lk] = sat32(p_att_q[lk], 1);
                p_suc_q[lk] = sat32(p_suc_q[lk], 32'(it.success));
                p_ret_q[lk] = sat32(p_ret_q[lk], 32'(it.retries));
            end else begin
                fold_stats(lk, sel_q[lk], 1, 32'(it.success), 32'(it.retries));
            end
            return;
        end
        if (probing_q) begin
            fold_stats(lk, pidx_q[lk], p_att_q[lk], p_suc_q[lk], p_ret_q[lk]);
            p_att_q[lk] = 0;
            p_suc_q[lk] = 0;
            p_ret_q[lk] = 0;
            probing_q = 0;
        end
        best = 0;
        best_t = 0;
        for (int i = 0; i < 8; i++) begin
            if (thr_q[lk][i] > best_t) begin
                best_t = thr_q[lk][i];
                best = i;
            end
        end
        o.rate_changed = (3'(best) != sel_q[lk]);
        sel_q[lk] = 3'(best);
        if (cdown_q[lk] == 0) begin
            pidx_q[lk] = sel_q[lk] + 3'd1;
            probing_q = 1;
            cdown_q[lk] = reload_q;
            probes_started++;
        end else begin
            cdown_q[lk]--;
        end
        o.out_link = 2'(lk);
        o.current_rate = sel_q[lk];
        o.probing_now = probing_q;
        o.probe_rate = pidx_q[lk];
        expected_ticks.push_back(o);
    endtask

    // sender
    int gap_left = 0;
    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            predict_item(s_data);
            sent_items++;
        end
        if (!s_valid || s_ready) begin
            if (gap_left > 0 || pending_items.size() == 0) begin
                if (gap_left > 0) gap_left--;
                s_valid <= 1'b0;
            end else begin
                s_data <= pending_items.pop_front();
                s_valid <= 1'b1;
                if (no_idle) gap_left = 0;
                else if ($urandom_range(0, 9) < 6) gap_left = 0;
                else if ($urandom_range(0, 9) < 8) gap_left = $urandom_range(1, 4);
                else gap_left = $urandom_range(20, 120);
            end
        end
    end

    // receiver: random stalls plus one long hold-off once results are flowing
    int  stall_left = 0;
    bit  long_hold_done = 0;
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            out_item_t want;
            ticks_seen++;
            if (expected_ticks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected tick result %p", m_data);
            end else begin
                want = expected_ticks.pop_front();
                if (m_data.out_link !== want.out_link ||
                    m_data.current_rate !== want.current_rate ||
                    m_data.rate_changed !== want.rate_changed ||
                    m_data.probing_now !== want.probing_now ||
                    m_data.probe_rate !== want.probe_rate) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tick %0d mismatch: expected %p, got %p",
                                 ticks_seen, want, m_data);
                end
            end
        end
        if (!long_hold_done && ticks_seen == 40) begin
            long_hold_done = 1;
            stall_left = 3000;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else if ($urandom_range(0, 19) == 0) begin
            stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 150)
                                                      : $urandom_range(1, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic in_item_t mk_item(bit op, int lk, bit suc, int rt, bit pf);
        in_item_t it;
        it.opcode = op;
        it.link_id = 2'(lk);
        it.success = suc;
        it.retries = 8'(rt);
        it.probe_frame = pf;
        return it;
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || expected_ticks.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [63:0] d);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        case (idx)
            CFG_ENABLE:   en_q = d[0];
            CFG_CODES_LO: codes_lo_q = d;
            CFG_CODES_HI: codes_hi_q = d;
            CFG_RELOAD:   reload_q = d[15:0];
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(int count);
        int lk;
        for (int n = 0; n < count; n++) begin
            lk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0;
            if ($urandom_range(0, 3) == 0)
                pending_items.push_back(mk_item(1, lk, 1'($urandom_range(0, 1)), 0,
                                                1'($urandom_range(0, 1))));
            else
                pending_items.push_back(mk_item(0, lk, $urandom_range(0, 3) != 0,
                                                $urandom_range(0, 255),
                                                1'($urandom_range(0, 1))));
        end
    endtask

    initial begin
        logic [15:0] reloads [5];
        en_q = 0;
        codes_lo_q = '0;
        codes_hi_q = '0;
        reload_q = 16'd10;
        probing_q = 0;
        for (int l = 0; l < 4; l++) begin
            sel_q[l] = 0; pidx_q[l] = 0; cdown_q[l] = 16'd10;
            p_att_q[l] = 0; p_suc_q[l] = 0; p_ret_q[l] = 0;
            for (int r = 0; r < 8; r++) begin
                att_q[l][r] = 0; suc_q[l][r] = 0; ret_q[l][r] = 0;
                fail_q[l][r] = 0; ewma_q[l][r] = 0; thr_q[l][r] = 0;
            end
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // disabled after reset: everything dropped
        pending_items.push_back(mk_item(0, 1, 1, 7, 0));
        pending_items.push_back(mk_item(1, 1, 0, 0, 0));
        pending_items.push_back(mk_item(1, 2, 1, 255, 1));
        wait_idle();

        write_reg(CFG_CODES_LO, 64'h0000_0001_8000_FFFF);
        write_reg(CFG_CODES_HI, 64'hFFFF_0000_1234_0002);
        write_reg(CFG_RELOAD, 16'd0);
        write_reg(CFG_ENABLE, 64'd1);

        // directed: status extremes, probe flag while not probing, countdown to a probe,
        // probe counting and the fold on the next tick
        pending_items.push_back(mk_item(0, 0, 1, 255, 0));
        pending_items.push_back(mk_item(0, 3, 0, 0, 1));
        pending_items.push_back(mk_item(0, 0, 1, 0, 1));
        for (int k = 0; k < 11; k++) pending_items.push_back(mk_item(1, 0, 0, 0, 0));
        pending_items.push_back(mk_item(0, 0, 1, 3, 1));
        pending_items.push_back(mk_item(0, 0, 0, 255, 1));
        pending_items.push_back(mk_item(0, 0, 1, 1, 0));
        pending_items.push_back(mk_item(1, 0, 1, 255, 1));
        pending_items.push_back(mk_item(1, 3, 0, 0, 0));
        pending_items.push_back(mk_item(1, 0, 0, 0, 0));
        wait_idle();

        reloads = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd2};
        for (int ph = 0; ph < 5; ph++) begin
            no_idle = (ph == 2);
            write_reg(CFG_CODES_LO, {pick_code(), pick_code(), pick_code(), pick_code()});
            write_reg(CFG_CODES_HI, {pick_code(), pick_code(), pick_code(), pick_code()});
            write_reg(CFG_RELOAD, reloads[ph]);
            random_phase(385);
            wait_idle();
        end
        no_idle = 0;

        // disabled again, then back on
        write_reg(CFG_ENABLE, 64'd0);
        random_phase(30);
        wait_idle();
        write_reg(CFG_ENABLE, 64'd1);
        write_reg(CFG_RELOAD, 16'd1);
        random_phase(20);
        wait_idle();

        $display("sent %0d transactions, checked %0d tick results, %0d probes started",
                 sent_items, ticks_seen, probes_started);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
